### rtl/hdlt_pkg.sv
`timescale 1ns / 1ps

package hdlt_pkg;

  // Default widths of the receive counter and the millisecond timer.
  localparam int unsigned LenBitsDefault  = 16;
  localparam int unsigned TimeBitsDefault = 16;

  // Command codes carried in an input word.
  typedef enum logic [2:0] {
    CMD_TICK        = 3'd0,
    CMD_RX_BYTE     = 3'd1,
    CMD_START_READ  = 3'd2,
    CMD_START_WRITE = 3'd3,
    CMD_TX_SENT     = 3'd4,
    CMD_ABORT       = 3'd5
  } cmd_e;

  // Status codes reported in a result word.
  localparam logic [1:0] STATUS_IDLE  = 2'd0;
  localparam logic [1:0] STATUS_WRITE = 2'd1;
  localparam logic [1:0] STATUS_READ  = 2'd2;

  // Transaction mode, one-hot.
  typedef enum logic [2:0] {
    MODE_IDLE  = 3'b001,
    MODE_WRITE = 3'b010,
    MODE_READ  = 3'b100
  } mode_e;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  rx_data;
    logic [15:0] length;
    logic [15:0] first_timeout;
    logic [15:0] gap_timeout;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        accepted;
    logic        drive_enable;
    logic        store_valid;
    logic [15:0] store_index;
    logic [7:0]  store_byte;
    logic        read_done;
    logic [15:0] read_len;
    logic        read_ok;
    logic        write_done;
  } out_word_t;

endpackage

### rtl/half_duplex_link_transaction_timer.sv
`timescale 1ns / 1ps

// Each result word is registered in the cycle after its input word is accepted.
// Throughput: one word per cycle; a new word is taken whenever the result register
// is empty or its word is taken in the same cycle.
// Reset: asynchronous, active low; the block comes up idle, receive direction,
// all counters and timeouts zero, and no result pending.
module half_duplex_link_transaction_timer #(
  parameter int unsigned LEN_BITS  = hdlt_pkg::LenBitsDefault,
  parameter int unsigned TIME_BITS = hdlt_pkg::TimeBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  hdlt_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output hdlt_pkg::out_word_t out_word_o
);
  import hdlt_pkg::*;

  localparam logic [TIME_BITS-1:0] TimeMax = {TIME_BITS{1'b1}};

  mode_e                mode_q, mode_d;
  logic [LEN_BITS-1:0]  rx_count_q, rx_count_d;
  logic [LEN_BITS-1:0]  rx_limit_q, rx_limit_d;
  logic [TIME_BITS-1:0] elapsed_q, elapsed_d;
  logic [TIME_BITS-1:0] active_to_q, active_to_d;
  logic [TIME_BITS-1:0] later_to_q, later_to_d;
  logic [LEN_BITS-1:0]  tx_left_q, tx_left_d;
  logic                 drive_q, drive_d;

  out_word_t            res_d, res_q;
  logic                 out_valid_q;
  logic                 in_fire;

  logic [31:0]          len_ext, first_ext, gap_ext, rx_count_ext;
  logic [TIME_BITS-1:0] elapsed_inc;

  // A word is taken when the result register is free or drains this cycle.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // Fit the 16-bit fields to the configured counter widths.
  assign len_ext      = 32'(in_word_i.length);
  assign first_ext    = 32'(in_word_i.first_timeout);
  assign gap_ext      = 32'(in_word_i.gap_timeout);
  assign rx_count_ext = 32'(rx_count_q);
  assign elapsed_inc  = (elapsed_q < TimeMax) ? elapsed_q + 1'b1 : elapsed_q;

  // Next state and result word for the word at the input.
  always_comb begin
    mode_d      = mode_q;
    rx_count_d  = rx_count_q;
    rx_limit_d  = rx_limit_q;
    elapsed_d   = elapsed_q;
    active_to_d = active_to_q;
    later_to_d  = later_to_q;
    tx_left_d   = tx_left_q;
    drive_d     = drive_q;
    res_d       = '0;

    unique case (in_word_i.cmd)
      CMD_TICK: begin
        if (mode_q == MODE_READ) begin
          elapsed_d = elapsed_inc;
          if (elapsed_inc >= active_to_q) begin
            res_d.read_done = 1'b1;
            res_d.read_len  = rx_count_ext[15:0];
            res_d.read_ok   = (rx_count_q != '0);
            mode_d          = MODE_IDLE;
            drive_d         = 1'b0;
          end
        end
      end
      CMD_RX_BYTE: begin
        if (mode_q == MODE_READ && rx_count_q < rx_limit_q) begin
          res_d.store_valid = 1'b1;
          res_d.store_index = rx_count_ext[15:0];
          res_d.store_byte  = in_word_i.rx_data;
          rx_count_d        = rx_count_q + 1'b1;
          elapsed_d         = '0;
          active_to_d       = later_to_q;
        end
      end
      CMD_START_READ: begin
        if (mode_q == MODE_IDLE) begin
          res_d.accepted = 1'b1;
          rx_limit_d     = len_ext[LEN_BITS-1:0];
          rx_count_d     = '0;
          elapsed_d      = '0;
          active_to_d    = first_ext[TIME_BITS-1:0];
          later_to_d     = gap_ext[TIME_BITS-1:0];
          drive_d        = 1'b0;
          mode_d         = MODE_READ;
        end
      end
      CMD_START_WRITE: begin
        if (mode_q == MODE_IDLE) begin
          res_d.accepted = 1'b1;
          // A zero-length write is acknowledged and leaves the block idle.
          if (len_ext[LEN_BITS-1:0] != '0) begin
            tx_left_d = len_ext[LEN_BITS-1:0];
            drive_d   = 1'b1;
            mode_d    = MODE_WRITE;
          end
        end
      end
      CMD_TX_SENT: begin
        if (mode_q == MODE_WRITE) begin
          tx_left_d = (tx_left_q != '0) ? tx_left_q - 1'b1 : tx_left_q;
          if (tx_left_d == '0) begin
            res_d.write_done = 1'b1;
            mode_d           = MODE_IDLE;
            drive_d          = 1'b0;
          end
        end
      end
      CMD_ABORT: begin
        mode_d    = MODE_IDLE;
        drive_d   = 1'b0;
        tx_left_d = '0;
      end
      default: begin
      end
    endcase

    unique case (mode_d)
      MODE_WRITE: res_d.status = STATUS_WRITE;
      MODE_READ:  res_d.status = STATUS_READ;
      default:    res_d.status = STATUS_IDLE;
    endcase
    res_d.drive_enable = drive_d;
  end

  // Transaction state, updated once per accepted word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      rx_count_q  <= '0;
      rx_limit_q  <= '0;
      elapsed_q   <= '0;
      active_to_q <= '0;
      later_to_q  <= '0;
      tx_left_q   <= '0;
      drive_q     <= 1'b0;
    end else if (in_fire) begin
      mode_q      <= mode_d;
      rx_count_q  <= rx_count_d;
      rx_limit_q  <= rx_limit_d;
      elapsed_q   <= elapsed_d;
      active_to_q <= active_to_d;
      later_to_q  <= later_to_d;
      tx_left_q   <= tx_left_d;
      drive_q     <= drive_d;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result word payload.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = res_q;

  // The line is driven exactly while a write is in progress.
  a_drive_matches_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drive_q == (mode_q == MODE_WRITE))
    else $error("drive line disagrees with mode");

  // A finished read reports the block idle and stores nothing.
  a_read_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.read_done) |->
      (res_q.status == STATUS_IDLE && !res_q.store_valid && !res_q.drive_enable))
    else $error("read completion with inconsistent result");

  // A stored byte always comes from an ongoing read within its limit.
  a_store_in_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.store_valid) |->
      (res_q.status == STATUS_READ && mode_q == MODE_READ && rx_count_q <= rx_limit_q))
    else $error("byte stored outside a read");

  // When the last byte is sent, the block returns to idle with the line released.
  a_write_done_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && mode_q == MODE_WRITE && tx_left_d == '0 && in_word_i.cmd == CMD_TX_SENT
      |=> mode_q == MODE_IDLE && !drive_q)
    else $error("write finished without returning to idle");

endmodule

### tb/half_duplex_link_transaction_timer_test.sv
`timescale 1ns / 1ps

module half_duplex_link_transaction_timer_test;
  import hdlt_pkg::*;

  localparam int unsigned RandomWords = 1150;
  localparam int unsigned TailWords   = 150;
  localparam int unsigned PauseAfter  = 500;
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned LimitCycles = 400000;

  // Command codes the block must ignore.
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  typedef struct {
    in_word_t word;
    bit       drain;
  } pending_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_word_t  in_word_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b1;
  out_word_t out_word_o;

  pending_t  word_q[$];
  out_word_t result_q[$];
  bit        hold_next = 1'b0;
  int        error_count = 0;
  int        send_gap = 0;
  int        stall_left = 0;
  int        cycle_count = 0;

  // Predicted state of the link controller.
  mode_e       link_mode = MODE_IDLE;
  logic [15:0] rx_count = '0;
  logic [15:0] rx_limit = '0;
  logic [15:0] ms_elapsed = '0;
  logic [15:0] ms_limit = '0;
  logic [15:0] gap_limit = '0;
  logic [15:0] tx_left = '0;
  logic        line_driven = 1'b0;

  half_duplex_link_transaction_timer DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

  always #6 clk_i = ~clk_i;

  // Advance the predicted controller by one word and return the result it reports.
  function automatic out_word_t link_step(input in_word_t w);
    out_word_t r;
    r = '0;
    case (w.cmd)
      CMD_TICK: begin
        if (link_mode == MODE_READ) begin
          if (ms_elapsed != 16'hFFFF) ms_elapsed = ms_elapsed + 16'd1;
          if (ms_elapsed >= ms_limit) begin
            r.read_done = 1'b1;
            r.read_len  = rx_count;
            r.read_ok   = (rx_count != 16'd0);
            link_mode   = MODE_IDLE;
            line_driven = 1'b0;
          end
        end
      end
      CMD_RX_BYTE: begin
        // A full buffer drops the byte and leaves the timer running.
        if (link_mode == MODE_READ && rx_count < rx_limit) begin
          r.store_valid = 1'b1;
          r.store_index = rx_count;
          r.store_byte  = w.rx_data;
          rx_count   = rx_count + 16'd1;
          ms_elapsed = '0;
          ms_limit   = gap_limit;
        end
      end
      CMD_START_READ: begin
        if (link_mode == MODE_IDLE) begin
          r.accepted  = 1'b1;
          rx_limit    = w.length;
          rx_count    = '0;
          ms_elapsed  = '0;
          ms_limit    = w.first_timeout;
          gap_limit   = w.gap_timeout;
          line_driven = 1'b0;
          link_mode   = MODE_READ;
        end
      end
      CMD_START_WRITE: begin
        // A zero-length write is accepted but leaves the block idle.
        if (link_mode == MODE_IDLE) begin
          r.accepted = 1'b1;
          if (w.length != 16'd0) begin
            tx_left     = w.length;
            line_driven = 1'b1;
            link_mode   = MODE_WRITE;
          end
        end
      end
      CMD_TX_SENT: begin
        if (link_mode == MODE_WRITE) begin
          if (tx_left != 16'd0) tx_left = tx_left - 16'd1;
          if (tx_left == 16'd0) begin
            r.write_done = 1'b1;
            link_mode    = MODE_IDLE;
            line_driven  = 1'b0;
          end
        end
      end
      CMD_ABORT: begin
        link_mode   = MODE_IDLE;
        line_driven = 1'b0;
        tx_left     = '0;
      end
      default: begin
      end
    endcase
    case (link_mode)
      MODE_WRITE: r.status = STATUS_WRITE;
      MODE_READ:  r.status = STATUS_READ;
      default:    r.status = STATUS_IDLE;
    endcase
    r.drive_enable = line_driven;
    return r;
  endfunction

  function automatic in_word_t any_word(input logic [2:0] code);
    in_word_t w;
    w = in_word_t'($bits(in_word_t)'({$urandom, $urandom}));
    w.cmd = code;
    return w;
  endfunction

  function automatic in_word_t start_word(input logic [2:0] code, input logic [15:0] len,
                                          input logic [15:0] t1, input logic [15:0] t2);
    in_word_t w;
    w = any_word(code);
    w.length = len;
    w.first_timeout = t1;
    w.gap_timeout = t2;
    return w;
  endfunction

  // Mostly small values, now and then any 16-bit value.
  function automatic logic [15:0] pick16(input int unsigned top);
    if ($urandom_range(0, 7) == 0) return 16'($urandom);
    return 16'($urandom_range(0, top));
  endfunction

  task automatic push_word(input in_word_t w);
    pending_t p;
    p.word = w;
    p.drain = hold_next;
    hold_next = 1'b0;
    word_q.push_back(p);
  endtask

  function automatic bit in_tail();
    return word_q.size() < TailWords;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // Driver: takes the next pending word once the current one is accepted.
  always @(posedge clk_i) begin
    pending_t next_p;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        result_q.push_back(link_step(in_word_i));
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (word_q.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (word_q[0].drain && result_q.size() != 0) begin
          // Hold off until every outstanding result has been returned.
          in_valid_i <= 1'b0;
        end else if (!in_tail() && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(1, 14) - 1;
          in_valid_i <= 1'b0;
        end else begin
          next_p = word_q.pop_front();
          in_valid_i <= 1'b1;
          in_word_i <= next_p.word;
        end
      end
    end
  end

  // Monitor: checks each returned word and stalls the result side at random.
  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (result_q.size() == 0) begin
          error_count++;
          $display("%0t: result %0h returned with no word outstanding", $time, out_word_o);
        end else begin
          want = result_q.pop_front();
          check_field("status", 16'(want.status), 16'(out_word_o.status));
          check_field("accepted", 16'(want.accepted), 16'(out_word_o.accepted));
          check_field("drive_enable", 16'(want.drive_enable), 16'(out_word_o.drive_enable));
          check_field("store_valid", 16'(want.store_valid), 16'(out_word_o.store_valid));
          check_field("store_index", want.store_index, out_word_o.store_index);
          check_field("store_byte", 16'(want.store_byte), 16'(out_word_o.store_byte));
          check_field("read_done", 16'(want.read_done), 16'(out_word_o.read_done));
          check_field("read_len", want.read_len, out_word_o.read_len);
          check_field("read_ok", 16'(want.read_ok), 16'(out_word_o.read_ok));
          check_field("write_done", 16'(want.write_done), 16'(out_word_o.write_done));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (!in_tail() && $urandom_range(0, 6) == 0) begin
        stall_left = $urandom_range(1, 14) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LimitCycles) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    in_word_t    w;
    int unsigned directed;
    int unsigned pick;
    int unsigned n;
    logic [15:0] len;
    logic [15:0] t1;
    logic [15:0] t2;
    bit          paused;

    paused = 1'b0;

    // Commands that an idle block ignores, and the spare codes.
    push_word(any_word(CMD_ABORT));
    push_word(any_word(CMD_TICK));
    w = any_word(CMD_RX_BYTE);
    w.rx_data = 8'hFF;
    push_word(w);
    push_word(any_word(CMD_TX_SENT));
    push_word(in_word_t'({CMD_SPARE_6, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}));
    push_word(in_word_t'({CMD_SPARE_7, 8'h00, 16'h0000, 16'h0000, 16'h0000}));
    // Zero-length write, then a zero-length read that ends by timeout.
    push_word(start_word(CMD_START_WRITE, 16'h0000, 16'hFFFF, 16'hFFFF));
    push_word(start_word(CMD_START_READ, 16'h0000, 16'd2, 16'hFFFF));
    push_word(any_word(CMD_RX_BYTE));
    push_word(any_word(CMD_TICK));
    push_word(any_word(CMD_TICK));
    // Widest read; starts while busy are refused; zero gap ends on the next tick.
    hold_next = 1'b1;
    push_word(start_word(CMD_START_READ, 16'hFFFF, 16'hFFFF, 16'h0000));
    push_word(start_word(CMD_START_READ, 16'h0001, 16'h0001, 16'h0001));
    push_word(start_word(CMD_START_WRITE, 16'd5, 16'h0000, 16'h0000));
    w = any_word(CMD_RX_BYTE);
    w.rx_data = 8'hFF;
    push_word(w);
    w = any_word(CMD_RX_BYTE);
    w.rx_data = 8'h00;
    push_word(w);
    push_word(any_word(CMD_TICK));
    // Widest write cut short by abort; ticks and bytes are ignored while writing.
    push_word(start_word(CMD_START_WRITE, 16'hFFFF, 16'h0000, 16'h0000));
    push_word(any_word(CMD_TICK));
    push_word(any_word(CMD_RX_BYTE));
    push_word(any_word(CMD_TX_SENT));
    push_word(any_word(CMD_ABORT));
    // Single-byte write, then a read with a zero first-byte timeout.
    push_word(start_word(CMD_START_WRITE, 16'h0001, 16'h0000, 16'h0000));
    push_word(any_word(CMD_TX_SENT));
    push_word(start_word(CMD_START_READ, 16'd3, 16'h0000, 16'h0000));
    push_word(any_word(CMD_TICK));
    directed = word_q.size();

    // Random transactions, each usually preceded by an abort.
    while (word_q.size() < directed + RandomWords) begin
      if (!paused && word_q.size() >= directed + PauseAfter) begin
        hold_next = 1'b1;
        paused = 1'b1;
      end
      if ($urandom_range(0, 3) != 0) push_word(any_word(CMD_ABORT));
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        // Read: bytes, ticks and now and then any code, then enough ticks to time out or an abort.
        len = pick16(6);
        t1 = pick16(5);
        t2 = pick16(4);
        push_word(start_word(CMD_START_READ, len, t1, t2));
        n = $urandom_range(0, 10);
        for (int i = 0; i < n; i++) begin
          pick = $urandom_range(0, 11);
          if (pick < 7) push_word(any_word(CMD_RX_BYTE));
          else if (pick < 11) push_word(any_word(CMD_TICK));
          else push_word(any_word(3'($urandom_range(0, 7))));
        end
        if (t1 <= 16'd8 && t2 <= 16'd8) begin
          repeat (9) push_word(any_word(CMD_TICK));
        end else begin
          repeat ($urandom_range(0, 3)) push_word(any_word(CMD_TICK));
          push_word(any_word(CMD_ABORT));
        end
      end else if (pick < 8) begin
        // Write: sent bytes down to zero, sometimes cut short.
        len = pick16(6);
        push_word(start_word(CMD_START_WRITE, len, 16'($urandom), 16'($urandom)));
        if (len <= 16'd8) begin
          for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0) begin
              push_word(any_word(CMD_ABORT));
              break;
            end
            if ($urandom_range(0, 3) == 0) begin
              push_word(any_word($urandom_range(0, 1) ? CMD_TICK : CMD_RX_BYTE));
            end
            push_word(any_word(CMD_TX_SENT));
          end
        end else begin
          repeat ($urandom_range(0, 3)) push_word(any_word(CMD_TX_SENT));
          push_word(any_word(CMD_ABORT));
        end
      end else begin
        repeat ($urandom_range(1, 4)) push_word(any_word(3'($urandom_range(0, 7))));
      end
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (word_q.size() != 0 || in_valid_i || result_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
    if (result_q.size() != 0) begin
      error_count++;
      $display("%0t: %0d results never returned", $time, result_q.size());
    end
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### sim.f
rtl/hdlt_pkg.sv
rtl/half_duplex_link_transaction_timer.sv
tb/half_duplex_link_transaction_timer_test.sv
